[rtl/sbd_pkg.sv]
// Shared types and constants for the single button dimmer.
`default_nettype none

package sbd_pkg;

  // Fixed field widths
  localparam int LEVEL_BITS  = 7;
  localparam int PERIOD_BITS = 16;
  localparam int STAMP_BITS  = 32;
  localparam int MS_BITS     = 10;
  // period * 1000 stays below 2^26
  localparam int SPAN_BITS   = PERIOD_BITS + MS_BITS;
  // 100 * span stays below 2^33
  localparam int SCALE_BITS  = SPAN_BITS + LEVEL_BITS;

  localparam logic [LEVEL_BITS-1:0]  FULL_LEVEL   = 7'd100;
  localparam logic [LEVEL_BITS-1:0]  MIN_LEVEL    = 7'd1;
  localparam logic [LEVEL_BITS-1:0]  RESET_SAVED  = 7'd50;
  localparam logic [PERIOD_BITS-1:0] RESET_PERIOD = 16'd2000;
  localparam logic [MS_BITS-1:0]     US_PER_MS    = 10'd1000;

  // Button event codes
  typedef enum logic [1:0] {
    OP_CLICK   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_START   = 2'd2,
    OP_HOLD    = 2'd3
  } op_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SPAN,
    ST_SCALE,
    ST_DIVIDE,
    ST_RAMP,
    ST_DELIVER
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;
    logic apply;
    logic span;
    logic scale;
    logic divide;
    logic ramp;
    logic deliver;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    op_t  op;
    logic bright_zero;
    logic holding;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

[rtl/sbd_event_if.sv]
// Button event channel: valid/ready handshake with operation and timestamp.
`default_nettype none

interface sbd_event_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      operation;
  logic [sbd_pkg::STAMP_BITS-1:0]  time_us;

  modport source (output valid, output operation, output time_us, input ready);
  modport sink   (input valid, input operation, input time_us, output ready);
endinterface

`default_nettype wire

[rtl/sbd_level_if.sv]
// Brightness result channel: valid/ready handshake with level and commit flag.
`default_nettype none

interface sbd_level_if;
  logic                            valid;
  logic                            ready;
  logic [sbd_pkg::LEVEL_BITS-1:0]  level;
  logic                            commit;

  modport source (output valid, output level, output commit, input ready);
  modport sink   (input valid, input level, input commit, output ready);
endinterface

`default_nettype wire

[rtl/sbd_ctrl.sv]
// Sequencing state machine of the dimmer: request intake, ramp divide count, delivery.
`default_nettype none

module sbd_ctrl #(
  parameter int FRACTION_BITS = 8
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire sbd_pkg::ctrl_sts_t  sts,
  output sbd_pkg::ctrl_cmd_t       cmd
);

  localparam int NUM_BITS = sbd_pkg::SCALE_BITS + FRACTION_BITS;
  localparam int CNT_BITS = $clog2(NUM_BITS);

  sbd_pkg::state_t      state, state_next;
  logic [CNT_BITS-1:0]  count;

  // Advance state and divide count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbd_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == sbd_pkg::ST_SCALE) begin
        count <= CNT_BITS'(NUM_BITS - 1);
      end else if (state == sbd_pkg::ST_DIVIDE) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

  // Pick next state
  always_comb begin
    state_next = state;
    case (state)
      sbd_pkg::ST_IDLE: begin
        if (in_valid) state_next = sbd_pkg::ST_APPLY;
      end
      sbd_pkg::ST_APPLY: begin
        case (sts.op)
          sbd_pkg::OP_CLICK:   state_next = sbd_pkg::ST_DELIVER;
          sbd_pkg::OP_RELEASE: state_next = sts.holding ? sbd_pkg::ST_DELIVER
                                                        : sbd_pkg::ST_IDLE;
          sbd_pkg::OP_START:   state_next = sbd_pkg::ST_IDLE;
          sbd_pkg::OP_HOLD:    state_next = sts.bright_zero ? sbd_pkg::ST_IDLE
                                                            : sbd_pkg::ST_SPAN;
          default:             state_next = sbd_pkg::ST_IDLE;
        endcase
      end
      sbd_pkg::ST_SPAN:   state_next = sbd_pkg::ST_SCALE;
      sbd_pkg::ST_SCALE:  state_next = sbd_pkg::ST_DIVIDE;
      sbd_pkg::ST_DIVIDE: begin
        if (count == '0) state_next = sbd_pkg::ST_RAMP;
      end
      sbd_pkg::ST_RAMP:   state_next = sbd_pkg::ST_DELIVER;
      sbd_pkg::ST_DELIVER: begin
        if (sts.out_free) state_next = sbd_pkg::ST_IDLE;
      end
      default: state_next = sbd_pkg::ST_IDLE;
    endcase
  end

  // Drive commands
  always_comb begin
    cmd         = '0;
    in_ready    = 1'b0;
    case (state)
      sbd_pkg::ST_IDLE: begin
        in_ready  = ~rst;
        cmd.latch = in_valid & ~rst;
      end
      sbd_pkg::ST_APPLY:   cmd.apply   = 1'b1;
      sbd_pkg::ST_SPAN:    cmd.span    = 1'b1;
      sbd_pkg::ST_SCALE:   cmd.scale   = 1'b1;
      sbd_pkg::ST_DIVIDE:  cmd.divide  = 1'b1;
      sbd_pkg::ST_RAMP:    cmd.ramp    = 1'b1;
      sbd_pkg::ST_DELIVER: cmd.deliver = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/sbd_datapath.sv]
// Dimmer datapath: level state, elapsed time scaling, serial divider, ramp and result register.
`default_nettype none

module sbd_datapath #(
  parameter int FRACTION_BITS = 8,
  parameter int TIME_BITS     = 32
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_write,
  input  wire [sbd_pkg::PERIOD_BITS-1:0]     cfg_data,
  input  wire [1:0]                          operation,
  input  wire [sbd_pkg::STAMP_BITS-1:0]      time_us,
  input  wire sbd_pkg::ctrl_cmd_t            cmd,
  output sbd_pkg::ctrl_sts_t                 sts,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [sbd_pkg::LEVEL_BITS-1:0]     out_level,
  output logic                               out_commit
);

  localparam int LB       = sbd_pkg::LEVEL_BITS;
  localparam int SB       = sbd_pkg::SPAN_BITS;
  localparam int NUM_BITS = sbd_pkg::SCALE_BITS + FRACTION_BITS;
  localparam int RW       = LB + FRACTION_BITS;
  localparam int EXT_BITS = (TIME_BITS > SB) ? TIME_BITS : SB;

  localparam logic [RW-1:0] FULL_FX = RW'(sbd_pkg::FULL_LEVEL) << FRACTION_BITS;
  localparam logic [RW-1:0] MIN_FX  = RW'(sbd_pkg::MIN_LEVEL) << FRACTION_BITS;

  // Configuration and level state
  logic [sbd_pkg::PERIOD_BITS-1:0] period;
  logic [LB-1:0]                   brightness;
  logic [LB-1:0]                   saved_level;
  logic [RW-1:0]                   ramp_value;
  logic                            ramp_up;
  logic                            holding;
  logic [TIME_BITS-1:0]            last_time;

  // Captured request and working registers
  sbd_pkg::op_t                    op_q;
  logic [TIME_BITS-1:0]            now_q;
  logic [TIME_BITS-1:0]            elapsed;
  logic [SB-1:0]                   span;
  logic [SB-1:0]                   rem;
  logic [NUM_BITS-1:0]             num;
  logic [LB-1:0]                   res_level;
  logic                            res_commit;

  // Combinational helpers
  logic [EXT_BITS-1:0]             elapsed_ext;
  logic [SB-1:0]                   capped;
  logic [sbd_pkg::SCALE_BITS-1:0]  scaled;
  logic [SB:0]                     rem_shift;
  logic                            qbit;
  logic [RW-1:0]                   step;
  logic [RW-1:0]                   ramp_next;
  logic [sbd_pkg::PERIOD_BITS-1:0] period_eff;

  assign period_eff  = (period == '0) ? sbd_pkg::PERIOD_BITS'(1) : period;
  assign elapsed_ext = EXT_BITS'(elapsed);
  assign capped      = (elapsed_ext > EXT_BITS'(span)) ? span : SB'(elapsed_ext);
  assign scaled      = sbd_pkg::SCALE_BITS'(capped) *
                       sbd_pkg::SCALE_BITS'(sbd_pkg::FULL_LEVEL);
  assign rem_shift   = {rem, num[NUM_BITS-1]};
  assign qbit        = (rem_shift >= {1'b0, span});
  assign step        = num[RW-1:0];

  // Saturating ramp move in the current direction
  always_comb begin
    if (ramp_up) begin
      if (ramp_value >= FULL_FX || step >= FULL_FX - ramp_value) begin
        ramp_next = FULL_FX;
      end else begin
        ramp_next = ramp_value + step;
      end
    end else begin
      if (ramp_value <= MIN_FX || step >= ramp_value - MIN_FX) begin
        ramp_next = MIN_FX;
      end else begin
        ramp_next = ramp_value - step;
      end
    end
  end

  // Hold the ramp period register
  always_ff @(posedge clk) begin
    if (rst) begin
      period <= sbd_pkg::RESET_PERIOD;
    end else if (cfg_write) begin
      period <= cfg_data;
    end
  end

  // Update level state per request
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness  <= '0;
      saved_level <= sbd_pkg::RESET_SAVED;
      ramp_value  <= '0;
      ramp_up     <= 1'b0;
      holding     <= 1'b0;
      last_time   <= '0;
    end else if (cmd.apply) begin
      case (op_q)
        sbd_pkg::OP_CLICK: begin
          if (brightness != '0) begin
            saved_level <= brightness;
            brightness  <= '0;
          end else begin
            brightness  <= saved_level;
          end
        end
        sbd_pkg::OP_RELEASE: begin
          holding <= 1'b0;
          if (holding && (ramp_value >= FULL_FX || ramp_value <= MIN_FX)) begin
            ramp_up <= ~ramp_up;
          end
        end
        sbd_pkg::OP_START: begin
          ramp_value <= RW'(brightness) << FRACTION_BITS;
          last_time  <= now_q;
        end
        sbd_pkg::OP_HOLD: begin
          if (brightness != '0) holding <= 1'b1;
        end
        default: holding <= holding;
      endcase
    end else if (cmd.span) begin
      last_time <= now_q;
    end else if (cmd.ramp) begin
      ramp_value <= ramp_next;
      brightness <= ramp_next[RW-1:FRACTION_BITS];
    end
  end

  // Capture request, scale elapsed time, run the restoring divider
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q  <= sbd_pkg::op_t'(operation);
      now_q <= TIME_BITS'(time_us);
    end
    if (cmd.span) begin
      elapsed <= now_q - last_time;
      span    <= SB'(period_eff * SB'(sbd_pkg::US_PER_MS));
    end
    if (cmd.scale) begin
      num <= NUM_BITS'(scaled) << FRACTION_BITS;
      rem <= '0;
    end else if (cmd.divide) begin
      rem <= qbit ? SB'(rem_shift - {1'b0, span}) : SB'(rem_shift);
      num <= {num[NUM_BITS-2:0], qbit};
    end
  end

  // Form the pending result
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      res_commit <= 1'b1;
      if (op_q == sbd_pkg::OP_CLICK) begin
        res_level <= (brightness != '0) ? '0 : saved_level;
      end else begin
        res_level <= brightness;
      end
    end else if (cmd.ramp) begin
      res_commit <= 1'b0;
      res_level  <= ramp_next[RW-1:FRACTION_BITS];
    end
  end

  // Output register: load on deliver, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.deliver) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      out_level  <= res_level;
      out_commit <= res_commit;
    end
  end

  assign sts.op          = op_q;
  assign sts.bright_zero = (brightness == '0);
  assign sts.holding     = holding;
  assign sts.out_free    = ~out_valid | out_ready;

endmodule

`default_nettype wire

[rtl/single_button_dimmer.sv]
// Single button dimmer, one request at a time. Click, and release after a hold: the request
// passes the apply and deliver states, then the result shows in the output register. Press start
// and requests with no result return to idle after the apply state. Long press hold: apply, span,
// scale, divide and ramp states before delivery, the divider giving one quotient bit per cycle
// over 33 + FRACTION_BITS numerator bits. A result waiting in the output register stalls delivery.
// Synchronous active-high reset: level 0, saved level 50, ramp down, ramp period 2000 ms.
`default_nettype none

module single_button_dimmer #(
  parameter int FRACTION_BITS = 8,
  parameter int TIME_BITS     = 32
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_write,
  input  wire [sbd_pkg::PERIOD_BITS-1:0]  cfg_data,
  sbd_event_if.sink                       button,
  sbd_level_if.source                     light
);

  sbd_pkg::ctrl_cmd_t cmd;
  sbd_pkg::ctrl_sts_t sts;

  // Sequence requests
  sbd_ctrl #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (button.valid),
    .in_ready (button.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Compute levels and hold the result
  sbd_datapath #(
    .FRACTION_BITS (FRACTION_BITS),
    .TIME_BITS     (TIME_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .operation  (button.operation),
    .time_us    (button.time_us),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (light.valid),
    .out_ready  (light.ready),
    .out_level  (light.level),
    .out_commit (light.commit)
  );

`ifndef SYNTHESIS
  // One request in flight: no accept right after an accept
  a_single_request: assert property (@(posedge clk) disable iff (rst)
    (button.valid && button.ready) |=> !button.ready)
    else $error("request accepted while another is in flight");

  // A delivered result shows on the output next cycle
  a_deliver_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.deliver |=> light.valid)
    else $error("delivered result not presented");

  // Delivery only into a free output register
  a_deliver_free: assert property (@(posedge clk) disable iff (rst)
    cmd.deliver |-> (!light.valid || light.ready))
    else $error("result overwrote a pending result");

  // Level stays within 0 to 100
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    light.valid |-> (light.level <= sbd_pkg::FULL_LEVEL))
    else $error("level out of range");
`endif

endmodule

`default_nettype wire
